>>> rtl/core/blf_pkg.sv
`timescale 1ns / 1ps

package blf_pkg;

    // Screen geometry and store layout
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PAGE_ROWS     = 8;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_BYTES   = PAGE_COUNT * SCREEN_WIDTH;
    localparam int ADDR_W        = $clog2(STORE_BYTES);

    // Fixed field widths
    localparam int X_W   = 7;
    localparam int Y_W   = 6;
    localparam int BA_W  = 10;
    // error term: |2*err| stays below 2*(127+63), so 10 bits signed is enough
    localparam int ERR_W = 10;

    // on-screen limits, wide enough for the largest screen
    localparam logic [8:0] WIDTH_LIMIT  = 9'(SCREEN_WIDTH);
    localparam logic [7:0] HEIGHT_LIMIT = 8'(SCREEN_HEIGHT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    typedef enum logic [1:0] {
        OP_LINE  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_LINE_RD,
        S_LINE_WR,
        S_READ_ADDR,
        S_READ_DATA,
        S_DONE
    } state_t;

    typedef struct packed {
        opcode_t           opcode;
        logic [X_W-1:0]    x_start;
        logic [Y_W-1:0]    y_start;
        logic [X_W-1:0]    x_end;
        logic [Y_W-1:0]    y_end;
        logic              pixel_on;
        logic [BA_W-1:0]   byte_address;
    } request_t;

    typedef struct packed {
        logic [7:0] read_data;
        opcode_t    finished_opcode;
    } response_t;

    // Frame store port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } store_req_t;

    // Line walker control and status
    typedef struct packed {
        logic load;
        logic step;
    } walk_ctrl_t;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic           at_end;
    } walk_status_t;

    // Byte index of a pixel: page times width plus column
    function automatic logic [ADDR_W-1:0] pixel_addr(input logic [X_W-1:0] x,
                                                     input logic [Y_W-1:0] y);
        pixel_addr = ADDR_W'(ADDR_W'(y[Y_W-1:3]) * ADDR_W'(SCREEN_WIDTH)) + ADDR_W'(x);
    endfunction

    // Bit of a pixel within its byte
    function automatic logic [7:0] pixel_mask(input logic [Y_W-1:0] y);
        pixel_mask = 8'd1 << y[2:0];
    endfunction

    function automatic logic on_screen(input logic [X_W-1:0] x,
                                       input logic [Y_W-1:0] y);
        on_screen = (9'(x) < WIDTH_LIMIT) && (8'(y) < HEIGHT_LIMIT);
    endfunction

endpackage

>>> rtl/core/blf_store.sv
`timescale 1ns / 1ps

module blf_store (
    input  logic                clk,
    input  blf_pkg::store_req_t req,
    output logic [7:0]          rd_data
);
    import blf_pkg::*;

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/blf_walk.sv
`timescale 1ns / 1ps

module blf_walk (
    input  logic                  clk,
    input  logic                  rst_n,
    input  blf_pkg::walk_ctrl_t   ctrl,
    input  blf_pkg::request_t     cmd,
    output blf_pkg::walk_status_t status
);
    import blf_pkg::*;

    logic [X_W-1:0]          x_reg, x_next;
    logic [Y_W-1:0]          y_reg, y_next;
    logic [X_W-1:0]          xb_reg, xb_next;
    logic [Y_W-1:0]          yb_reg, yb_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic signed [ERR_W-1:0] dx_reg, dx_next;
    logic signed [ERR_W-1:0] dy_reg, dy_next;
    logic                    sx_neg_reg, sx_neg_next;
    logic                    sy_neg_reg, sy_neg_next;

    logic signed [ERR_W:0]   twice;
    logic                    move_x;
    logic                    move_y;
    logic [X_W-1:0]          adx;
    logic [Y_W-1:0]          ady;

    // Setup and one Bresenham step per request
    always_comb
    begin
        x_next      = x_reg;
        y_next      = y_reg;
        xb_next     = xb_reg;
        yb_next     = yb_reg;
        err_next    = err_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        sx_neg_next = sx_neg_reg;
        sy_neg_next = sy_neg_reg;

        twice  = {err_reg, 1'b0};
        move_x = twice >= (ERR_W + 1)'(dy_reg);
        move_y = twice <= (ERR_W + 1)'(dx_reg);

        adx = (cmd.x_end > cmd.x_start) ? cmd.x_end - cmd.x_start
                                        : cmd.x_start - cmd.x_end;
        ady = (cmd.y_end > cmd.y_start) ? cmd.y_end - cmd.y_start
                                        : cmd.y_start - cmd.y_end;

        if (ctrl.load)
        begin
            x_next      = cmd.x_start;
            y_next      = cmd.y_start;
            xb_next     = cmd.x_end;
            yb_next     = cmd.y_end;
            dx_next     = ERR_W'(adx);
            dy_next     = -ERR_W'(ady);
            err_next    = ERR_W'(adx) - ERR_W'(ady);
            sx_neg_next = !(cmd.x_start < cmd.x_end);
            sy_neg_next = !(cmd.y_start < cmd.y_end);
        end
        else if (ctrl.step)
        begin
            err_next = err_reg + (move_x ? dy_reg : '0) + (move_y ? dx_reg : '0);
            if (move_x)
            begin
                x_next = sx_neg_reg ? x_reg - 1'b1 : x_reg + 1'b1;
            end
            if (move_y)
            begin
                y_next = sy_neg_reg ? y_reg - 1'b1 : y_reg + 1'b1;
            end
        end
    end

    // Walker registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg      <= '0;
            y_reg      <= '0;
            xb_reg     <= '0;
            yb_reg     <= '0;
            err_reg    <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            sx_neg_reg <= 1'b0;
            sy_neg_reg <= 1'b0;
        end
        else
        begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            xb_reg     <= xb_next;
            yb_reg     <= yb_next;
            err_reg    <= err_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            sx_neg_reg <= sx_neg_next;
            sy_neg_reg <= sy_neg_next;
        end
    end

    assign status.x      = x_reg;
    assign status.y      = y_reg;
    assign status.at_end = (x_reg == xb_reg) && (y_reg == yb_reg);

endmodule

>>> rtl/core/bresenham_line_framebuffer.sv
`timescale 1ns / 1ps

// One-bit-per-pixel frame store of 128 by 64 pixels in pages of eight rows
// (byte (y/8)*128+x, bit y mod 8) with a Bresenham line engine. Requests are
// taken one at a time; request_stall stays high until the current request
// finishes. Each pixel of a line is a read-modify-write of its byte, a read
// state and then a write-back state, because a byte holds eight pixels. A
// clear sweeps one byte per cycle; a byte read passes through an address
// state and a data state. After reset the block runs a clearing pass over
// the store and holds request_stall high meanwhile. Each request gives one
// response; a finished response waits in an output register, and the next
// request is accepted while it waits.
module bresenham_line_framebuffer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                request_valid,
    output logic                request_stall,
    input  blf_pkg::request_t   request,
    output logic                response_valid,
    input  logic                response_stall,
    output blf_pkg::response_t  response
);
    import blf_pkg::*;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;
    request_t          cmd_reg, cmd_next;
    response_t         res_reg, res_next;
    response_t         out_reg, out_next;

    store_req_t        store_req;
    logic [7:0]        rd_data;
    walk_ctrl_t        walk_ctrl;
    walk_status_t      walk_status;
    logic [ADDR_W-1:0] pix_addr;
    logic [7:0]        pix_mask;

    blf_store u_store (
        .clk     (clk),
        .req     (store_req),
        .rd_data (rd_data)
    );

    // The walker loads straight from the request port at accept
    blf_walk u_walk (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (walk_ctrl),
        .cmd    (request),
        .status (walk_status)
    );

    assign pix_addr = pixel_addr(walk_status.x, walk_status.y);
    assign pix_mask = pixel_mask(walk_status.y);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        store_req      = '0;
        walk_ctrl      = '0;
        request_stall  = 1'b1;

        if (out_valid_reg && !response_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                store_req.we    = 1'b1;
                store_req.waddr = clr_cnt_reg;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    clr_cnt_next = '0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                request_stall = 1'b0;
                if (request_valid)
                begin
                    cmd_next       = request;
                    walk_ctrl.load = 1'b1;
                    case (request.opcode)
                        OP_LINE:  state_next = S_LINE_RD;
                        OP_CLEAR: state_next = S_CLEAR;
                        OP_READ:  state_next = S_READ_ADDR;
                        default:
                        begin
                            res_next.read_data       = '0;
                            res_next.finished_opcode = request.opcode;
                            state_next               = S_DONE;
                        end
                    endcase
                end
            end

            S_CLEAR:
            begin
                store_req.we    = 1'b1;
                store_req.waddr = clr_cnt_reg;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    clr_cnt_next             = '0;
                    res_next.read_data       = '0;
                    res_next.finished_opcode = OP_CLEAR;
                    state_next               = S_DONE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            // fetch the byte under the current pixel
            S_LINE_RD:
            begin
                store_req.raddr = pix_addr;
                state_next      = S_LINE_WR;
            end

            // write it back modified, then step or finish
            S_LINE_WR:
            begin
                store_req.we    = on_screen(walk_status.x, walk_status.y);
                store_req.waddr = pix_addr;
                store_req.wdata = cmd_reg.pixel_on ? (rd_data | pix_mask)
                                                   : (rd_data & ~pix_mask);
                if (walk_status.at_end)
                begin
                    res_next.read_data       = '0;
                    res_next.finished_opcode = OP_LINE;
                    state_next               = S_DONE;
                end
                else
                begin
                    walk_ctrl.step = 1'b1;
                    state_next     = S_LINE_RD;
                end
            end

            S_READ_ADDR:
            begin
                store_req.raddr = ADDR_W'(cmd_reg.byte_address);
                state_next      = S_READ_DATA;
            end

            // an address past the store reads as zero
            S_READ_DATA:
            begin
                res_next.read_data = (int'(cmd_reg.byte_address) < STORE_BYTES)
                                     ? rd_data : 8'd0;
                res_next.finished_opcode = OP_READ;
                state_next               = S_DONE;
            end

            // hand the response over once the output register is free
            S_DONE:
            begin
                if (!out_valid_reg || !response_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign response_valid = out_valid_reg;
    assign response       = out_reg;

    // Store is only written by the clearing sweeps and the line write-back
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        store_req.we |-> (state_reg == S_INIT || state_reg == S_CLEAR ||
                          state_reg == S_LINE_WR))
        else $error("frame store written outside a write state");

    // An accepted request always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (request_valid && !request_stall) |=> (state_reg != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // Reaching the end point of a line finishes the walk
    a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINE_WR && walk_status.at_end) |=> (state_reg == S_DONE))
        else $error("line walk did not finish at its end point");

    // The sequencer never sits on a busy state while accepting
    a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !request_stall |-> (state_reg == S_IDLE && clr_cnt_reg == '0))
        else $error("request port open outside idle");

endmodule
